// ===== sv/rar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rodrigues rotation package
// Shared types, fixed formats and elaboration-time constant functions.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int DW = 32;   // stream coordinate width
    localparam int SW = 33;   // saturated intermediate width
    localparam int PW = 66;   // product and sum width
    localparam int CW = 34;   // CORDIC datapath width
    localparam int UW = 35;   // angle reduction width

    localparam longint DEG2RAD_Q32    = 64'sd74961321;
    localparam longint QUARTER_PI_Q30 = 64'sd843314857;
    localparam longint ONE_Q30        = 64'sd1 << 30;
    localparam longint SAT33          = 64'sd4294967295;

    typedef logic signed [DW-1:0] word_t;
    typedef logic signed [SW-1:0] sword_t;
    typedef logic signed [PW-1:0] wide_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
    } vec3_t;

    typedef struct packed {
        sword_t x;
        sword_t y;
        sword_t z;
    } svec3_t;

    typedef struct packed {
        vec3_t  v;
        svec3_t cr;
        svec3_t kd;
    } vterm_t;

    typedef struct packed {
        word_t sn;
        word_t cs;
    } trig_t;

    // Unsigned 64-bit quotient by shift and subtract, used only while elaborating.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int bi = 63; bi >= 0; bi--) begin
            rem = {rem[62:0], num[bi]};
            if (rem >= den) begin
                rem   = rem - den;
                q[bi] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q30, summed from its power series in Q62.
    function automatic longint atan_q30(input int i);
        longint            acc;
        longint unsigned   term;
        int                e;
        acc = 0;
        if (i == 0) begin
            return QUARTER_PI_Q30;
        end
        for (int n = 0; n < 64; n++) begin
            e = 62 - i * (2 * n + 1);
            if (e >= 0) begin
                term = udiv64(64'd1 << e, 64'(2 * n + 1));
                if ((n & 1) == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
        end
        return (acc + (64'sd1 << 31)) >>> 32;
    endfunction

    function automatic longint unsigned isqrt64(input longint unsigned xin);
        longint unsigned x;
        longint unsigned res;
        longint unsigned bitv;
        x    = xin;
        res  = 0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bitv > x) begin
                bitv = bitv >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (bitv != 0) begin
                if (x >= res + bitv) begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // Inverse CORDIC gain in Q30.
    function automatic longint gain_q30(input int stages);
        longint unsigned p;
        longint unsigned s;
        p = 64'd1 << 60;
        for (int i = 0; i < 64; i++) begin
            if (i < stages) begin
                p = p + (p >> (2 * i));
            end
        end
        s = isqrt64(p);
        return longint'(udiv64((64'd1 << 60) + (s >> 1), s));
    endfunction

    // Shift that makes 360 degrees times a power of two reach 2^31.
    function automatic int kf_shift(input int frac);
        longint full;
        int     r;
        full = 64'sd360 << frac;
        r    = 0;
        for (int n = 0; n < 40; n++) begin
            if ((full << r) < (64'sd1 << 31)) begin
                r = r + 1;
            end
        end
        return r;
    endfunction

    // Number of conditional subtract steps of the modulo-360 reduction.
    function automatic int mod_steps(input int frac);
        longint full;
        longint umax;
        int     r;
        full = 64'sd360 << frac;
        umax = (64'sd1 << 31) - 1 + (full << kf_shift(frac));
        r    = 0;
        for (int n = 0; n < 40; n++) begin
            if ((full << r) <= umax) begin
                r = r + 1;
            end
        end
        return r;
    endfunction

    function automatic sword_t sat33(input wide_t x);
        if (x > wide_t'(SAT33)) begin
            return sword_t'(SAT33);
        end else if (x < -wide_t'(SAT33)) begin
            return -sword_t'(SAT33);
        end
        return x[SW-1:0];
    endfunction

    function automatic word_t sat32(input wide_t x);
        if (x > wide_t'(64'sd2147483647)) begin
            return word_t'(64'sd2147483647);
        end else if (x < -wide_t'(64'sd2147483648)) begin
            return word_t'(-64'sd2147483648);
        end
        return x[DW-1:0];
    endfunction

endpackage

// ===== sv/rar_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rodrigues rotation sine/cosine pipeline
// Modulo-360 reduction, quadrant fold, degree-to-radian scaling and a
// rotation-mode CORDIC, one register stage per step.
// ----------------------------------------------------------------------------
module rar_sincos import rar_pkg::*; #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic  aclk,
    input  logic  en,
    input  word_t angle,
    output trig_t trig
);

    localparam int     AW      = FRAC_BITS + 10;
    localparam int     MW      = AW + 28;
    localparam int     QB      = mod_steps(FRAC_BITS);
    localparam longint FULL    = 64'sd360 << FRAC_BITS;
    localparam longint HALF    = 64'sd180 << FRAC_BITS;
    localparam longint QUARTER = 64'sd90 << FRAC_BITS;
    localparam longint KF      = FULL << kf_shift(FRAC_BITS);

    localparam logic signed [CW-1:0] GAIN = CW'(gain_q30(CORDIC_STAGES));
    localparam logic signed [CW-1:0] ONE  = CW'(ONE_Q30);

    logic [UW-1:0] u_reg [0:QB];

    logic signed [AW-1:0] a0;
    logic signed [AW-1:0] ah;
    logic signed [AW-1:0] a_next;
    logic                 fneg_next;
    logic signed [AW-1:0] a_reg;
    logic                 aneg_reg;
    logic signed [MW-1:0] p_reg;
    logic                 pneg_reg;
    logic signed [CW-1:0] z0;

    logic signed [CW-1:0] cx_reg [0:CORDIC_STAGES-1];
    logic signed [CW-1:0] cy_reg [0:CORDIC_STAGES-1];
    logic signed [CW-1:0] cz_reg [0:CORDIC_STAGES-1];
    logic                 cn_reg [0:CORDIC_STAGES-1];

    logic signed [CW-1:0] xo;
    logic signed [CW-1:0] yo;
    trig_t                trig_next;
    trig_t                trig_reg;

    // Offset by a multiple of 360 degrees so the value is never negative.
    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg[0] <= {{(UW-DW){angle[DW-1]}}, angle} + UW'(KF);
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_mod
        localparam logic [UW-1:0] SUBV = UW'(FULL << (QB - 1 - j));
        always_ff @(posedge aclk) begin
            if (en) begin
                u_reg[j+1] <= (u_reg[j] >= SUBV) ? u_reg[j] - SUBV : u_reg[j];
            end
        end
    end

    always_comb begin
        a0        = signed'({1'b0, u_reg[QB][AW-2:0]});
        ah        = (a0 >= AW'(HALF)) ? a0 - AW'(FULL) : a0;
        a_next    = ah;
        fneg_next = 1'b0;
        if (ah > AW'(QUARTER)) begin
            a_next    = ah - AW'(HALF);
            fneg_next = 1'b1;
        end else if (ah < -AW'(QUARTER)) begin
            a_next    = ah + AW'(HALF);
            fneg_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg    <= a_next;
            aneg_reg <= fneg_next;
            p_reg    <= MW'(a_reg) * MW'(DEG2RAD_Q32);
            pneg_reg <= aneg_reg;
        end
    end

    assign z0 = CW'((p_reg + MW'(64'sd1 << (FRAC_BITS + 1))) >>> (FRAC_BITS + 2));

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        localparam logic signed [CW-1:0] AT = CW'(atan_q30(i));
        logic signed [CW-1:0] xi;
        logic signed [CW-1:0] yi;
        logic signed [CW-1:0] zi;
        logic                 ni;
        if (i == 0) begin : g_first
            assign xi = GAIN;
            assign yi = '0;
            assign zi = z0;
            assign ni = pneg_reg;
        end else begin : g_next
            assign xi = cx_reg[i-1];
            assign yi = cy_reg[i-1];
            assign zi = cz_reg[i-1];
            assign ni = cn_reg[i-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (zi >= 0) begin
                    cx_reg[i] <= xi - (yi >>> i);
                    cy_reg[i] <= yi + (xi >>> i);
                    cz_reg[i] <= zi - AT;
                end else begin
                    cx_reg[i] <= xi + (yi >>> i);
                    cy_reg[i] <= yi - (xi >>> i);
                    cz_reg[i] <= zi + AT;
                end
                cn_reg[i] <= ni;
            end
        end
    end

    always_comb begin
        xo = cn_reg[CORDIC_STAGES-1] ? -cx_reg[CORDIC_STAGES-1] : cx_reg[CORDIC_STAGES-1];
        yo = cn_reg[CORDIC_STAGES-1] ? -cy_reg[CORDIC_STAGES-1] : cy_reg[CORDIC_STAGES-1];
        if (xo > ONE) begin
            xo = ONE;
        end else if (xo < -ONE) begin
            xo = -ONE;
        end
        if (yo > ONE) begin
            yo = ONE;
        end else if (yo < -ONE) begin
            yo = -ONE;
        end
        trig_next.cs = xo[DW-1:0];
        trig_next.sn = yo[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

// ===== sv/rar_vec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rodrigues rotation vector terms
// Cross product k x v, dot product k.v and k*(k.v), rounded and saturated,
// in four register stages.
// ----------------------------------------------------------------------------
module rar_vec import rar_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic   aclk,
    input  logic   en,
    input  vec3_t  v,
    input  vec3_t  k,
    output vterm_t vt
);

    localparam wide_t RHALF = wide_t'(64'sd1 << (FRAC_BITS - 1));

    word_t  va [0:2];
    word_t  ka [0:2];
    wide_t  pa_reg [0:2];
    wide_t  pb_reg [0:2];
    wide_t  pd_reg [0:2];
    vec3_t  v1_reg, v2_reg, v3_reg;
    word_t  k1_reg [0:2];
    word_t  k2_reg [0:2];
    sword_t cr_reg [0:2];
    sword_t cr3_reg [0:2];
    sword_t dot_reg;
    wide_t  pk_reg [0:2];
    sword_t kd_next [0:2];
    wide_t  dsum;

    assign va[0] = v.x;
    assign va[1] = v.y;
    assign va[2] = v.z;
    assign ka[0] = k.x;
    assign ka[1] = k.y;
    assign ka[2] = k.z;

    assign dsum = pd_reg[0] + pd_reg[1] + pd_reg[2] + RHALF;

    for (genvar j = 0; j < 3; j++) begin : g_lane
        localparam int A = (j + 1) % 3;
        localparam int B = (j + 2) % 3;
        assign kd_next[j] = sat33((pk_reg[j] + RHALF) >>> FRAC_BITS);
        always_ff @(posedge aclk) begin
            if (en) begin
                pa_reg[j]  <= wide_t'(ka[A]) * wide_t'(va[B]);
                pb_reg[j]  <= wide_t'(va[A]) * wide_t'(ka[B]);
                pd_reg[j]  <= wide_t'(ka[j]) * wide_t'(va[j]);
                k1_reg[j]  <= ka[j];
                cr_reg[j]  <= sat33((pa_reg[j] - pb_reg[j] + RHALF) >>> FRAC_BITS);
                k2_reg[j]  <= k1_reg[j];
                pk_reg[j]  <= wide_t'(k2_reg[j]) * wide_t'(dot_reg);
                cr3_reg[j] <= cr_reg[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg  <= v;
            v2_reg  <= v1_reg;
            dot_reg <= sat33(dsum >>> FRAC_BITS);
            v3_reg  <= v2_reg;
            vt.v    <= v3_reg;
            vt.cr   <= {cr3_reg[0], cr3_reg[1], cr3_reg[2]};
            vt.kd   <= {kd_next[0], kd_next[1], kd_next[2]};
        end
    end

endmodule

// ===== sv/rar_combine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rodrigues rotation combine stage
// Scales the three terms by cos, sin and 1-cos, rounds and saturates.
// ----------------------------------------------------------------------------
module rar_combine import rar_pkg::*; (
    input  logic   aclk,
    input  logic   en,
    input  vterm_t vt,
    input  trig_t  tr,
    output vec3_t  r
);

    localparam wide_t RND30 = wide_t'(64'sd1 << 29);

    word_t  va  [0:2];
    sword_t cra [0:2];
    sword_t kda [0:2];
    sword_t omc;
    wide_t  p1_reg [0:2];
    wide_t  p2_reg [0:2];
    wide_t  p3_reg [0:2];
    word_t  r_next [0:2];
    vec3_t  r_reg;

    assign va[0]  = vt.v.x;
    assign va[1]  = vt.v.y;
    assign va[2]  = vt.v.z;
    assign cra[0] = vt.cr.x;
    assign cra[1] = vt.cr.y;
    assign cra[2] = vt.cr.z;
    assign kda[0] = vt.kd.x;
    assign kda[1] = vt.kd.y;
    assign kda[2] = vt.kd.z;
    assign omc    = sword_t'(ONE_Q30) - sword_t'(tr.cs);

    for (genvar j = 0; j < 3; j++) begin : g_lane
        always_ff @(posedge aclk) begin
            if (en) begin
                p1_reg[j] <= wide_t'(va[j]) * wide_t'(tr.cs);
                p2_reg[j] <= wide_t'(cra[j]) * wide_t'(tr.sn);
                p3_reg[j] <= wide_t'(kda[j]) * wide_t'(omc);
            end
        end
        assign r_next[j] = sat32(((p1_reg[j] + RND30) >>> 30) + ((p2_reg[j] + RND30) >>> 30)
                                 + ((p3_reg[j] + RND30) >>> 30));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= {r_next[0], r_next[1], r_next[2]};
        end
    end

    assign r = r_reg;

endmodule

// ===== sv/rodrigues_axis_angle_rotate.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle while the output is not stalled.
// The CORDIC and the multiplier stages are all pipelined.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset (aresetn low, synchronous) clears the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// Rodrigues axis-angle rotation
// Rotates a Q15.16 vector about an axis by an angle in degrees, one request
// per cycle unless stalled, using CORDIC sine and cosine; the result saturates.
// ----------------------------------------------------------------------------
module rodrigues_axis_angle_rotate import rar_pkg::*; #(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // v_x, v_y, v_z, axis_x, axis_y, axis_z, angle_deg (32 bits each, lowest first)
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // r_x, r_y, r_z (32 bits each, lowest first)
    output logic [95:0]  m_tdata
);

    // The angle path sets the depth: reduction steps, fold, radian scaling,
    // CORDIC stages and the clamp. The vector path takes four stages and is
    // delayed to meet it; the combine stage adds two more.
    localparam int LSC = mod_steps(FRAC_BITS) + CORDIC_STAGES + 4;
    localparam int LV  = 4;
    localparam int DLY = LSC - LV;
    localparam int LAT = LSC + 2;

    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    vec3_t          v_in;
    vec3_t          k_in;
    trig_t          trig;
    vterm_t         vt;
    vterm_t         dl_reg [0:DLY-1];
    vec3_t          r;

    // A single stall enable: every stage moves when the result register can
    // take a new value. The valid bits shift along with the data.
    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    assign v_in = '{x: s_tdata[31:0],    y: s_tdata[63:32],   z: s_tdata[95:64]};
    assign k_in = '{x: s_tdata[127:96],  y: s_tdata[159:128], z: s_tdata[191:160]};

    rar_sincos #(
        .FRAC_BITS     (FRAC_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_sincos (
        .aclk  (aclk),
        .en    (en),
        .angle (s_tdata[223:192]),
        .trig  (trig)
    );

    rar_vec #(
        .FRAC_BITS (FRAC_BITS)
    ) u_vec (
        .aclk (aclk),
        .en   (en),
        .v    (v_in),
        .k    (k_in),
        .vt   (vt)
    );

    // Delay line that aligns the vector terms with sine and cosine.
    for (genvar d = 0; d < DLY; d++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (en) begin
                dl_reg[d] <= (d == 0) ? vt : dl_reg[(d == 0) ? 0 : d - 1];
            end
        end
    end

    rar_combine u_combine (
        .aclk (aclk),
        .en   (en),
        .vt   (dl_reg[DLY-1]),
        .tr   (trig),
        .r    (r)
    );

    assign m_tdata = {r.z, r.y, r.x};

endmodule

// ===== sv/rar_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rodrigues rotation port checker
// Checks stall behavior and reset on the top-level ports.
// ----------------------------------------------------------------------------
module rar_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output state");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
        else $error("request accepted while pipeline stalled");

endmodule

bind rodrigues_axis_angle_rotate rar_checker u_rar_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/rodrigues_axis_angle_rotate_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rodrigues rotation testbench
// Drives vector, axis and angle requests with random gaps, predicts each
// rotated vector in fixed point and compares every result field by field.
// ----------------------------------------------------------------------------
module rodrigues_axis_angle_rotate_tb;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY       = 30;
    localparam int RANDOM_ITEMS  = 1530;
    localparam int WATCHDOG_MAX  = 2000;

    // Shape of a directed row: a fixed result is only typed in where it is obvious.
    typedef struct {
        logic [31:0] f[7];
        bit          has_fixed;
        logic [31:0] fixed[3];
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;

    logic [95:0]  rotated_q[$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    bit           timed_out = 1'b0;
    longint       atan_tab[CORDIC_STAGES];
    longint       cordic_gain;

    // Directed angles: zero, quadrants, wrap beyond 360 and negative angles.
    logic [31:0] ang_list[10] = '{32'h0000_0000, 32'h005a_0000, 32'h00b4_0000,
                                  32'h010e_0000, 32'h0168_0000, 32'hffa6_0000,
                                  32'hff4c_0000, 32'h02d0_8000, 32'h7fff_ffff,
                                  32'h8000_0000};

    rodrigues_axis_angle_rotate #(
        .FRAC_BITS(FRAC_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Arithmetic shift right with floor, on 64-bit signed values.
    function automatic longint floor_shift(input longint v, input int n);
        return v >>> n;
    endfunction

    // Round half up: add half an LSB, then floor. The 64-bit sum can not
    // overflow for the magnitudes used below.
    function automatic longint round_q(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Stage angles and gain are rebuilt here from their definitions.
    task automatic build_cordic_tables();
        longint acc;
        longint unsigned p, s, x, res, b;
        int e;
        atan_tab[0] = 64'sd843314857;
        for (int i = 1; i < CORDIC_STAGES; i++) begin
            acc = 0;
            for (int n = 0; n < 64; n++) begin
                e = 62 - i * (2 * n + 1);
                if (e >= 0) begin
                    acc += ((n & 1) ? -1 : 1) * longint'((64'd1 << e) / (2 * n + 1));
                end
            end
            atan_tab[i] = (acc + (64'sd1 << 31)) >>> 32;
        end
        p = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            p += p >> (2 * i);
        end
        x = p;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) begin
            b >>= 2;
        end
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        s = res;
        cordic_gain = longint'(((64'd1 << 60) + s / 2) / s);
    endtask

    // Sine and cosine of an angle in degrees, both in Q30.
    function automatic void sin_cos_deg(input logic signed [31:0] deg, output longint sn,
                                        output longint cs);
        longint full, half, quarter, a, x, y, z, dx, dy;
        bit flip;
        full = 64'sd360 << FRAC_BITS;
        half = 64'sd180 << FRAC_BITS;
        quarter = 64'sd90 << FRAC_BITS;
        flip = 1'b0;
        a = longint'(deg) % full;
        if (a < 0) a += full;
        if (a >= half) a -= full;
        if (a > quarter) begin
            a -= half;
            flip = 1'b1;
        end else if (a < -quarter) begin
            a += half;
            flip = 1'b1;
        end
        z = round_q(a * 64'sd74961321, FRAC_BITS + 2);
        x = cordic_gain;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = clip(x, -(64'sd1 << 30), 64'sd1 << 30);
        sn = clip(y, -(64'sd1 << 30), 64'sd1 << 30);
    endfunction

    // Full rotation of one request; returns r_x, r_y, r_z packed lowest first.
    function automatic logic [95:0] rotate_vector(input logic [223:0] req);
        longint v[3], k[3], cr[3], sn, cs, omc, dot, kd, r;
        logic [95:0] out;
        int a, b;
        for (int j = 0; j < 3; j++) begin
            v[j] = longint'($signed(req[32*j +: 32]));
            k[j] = longint'($signed(req[32*(3+j) +: 32]));
        end
        sin_cos_deg(req[192 +: 32], sn, cs);
        omc = (64'sd1 << 30) - cs;
        for (int j = 0; j < 3; j++) begin
            a = (j + 1) % 3;
            b = (j + 2) % 3;
            // Each product fits in 63 bits and their difference stays inside 64 bits.
            cr[j] = clip(round_q(k[a] * v[b] - v[a] * k[b], FRAC_BITS),
                         -64'sd4294967295, 64'sd4294967295);
        end
        // The three-term dot product may exceed 64 bits; split into high and low parts.
        begin
            longint hi, lo;
            hi = 0;
            lo = 0;
            for (int j = 0; j < 3; j++) begin
                hi += floor_shift(k[j] * v[j], FRAC_BITS);
                lo += (k[j] * v[j]) & ((64'sd1 << FRAC_BITS) - 1);
            end
            dot = clip(hi + ((lo + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS),
                       -64'sd4294967295, 64'sd4294967295);
        end
        for (int j = 0; j < 3; j++) begin
            kd = clip(round_q(k[j] * dot, FRAC_BITS), -64'sd4294967295, 64'sd4294967295);
            r = round_q(v[j] * cs, 30) + round_q(cr[j] * sn, 30) + round_q(kd * omc, 30);
            r = clip(r, -64'sd2147483648, 64'sd2147483647);
            out[32*j +: 32] = r[31:0];
        end
        return out;
    endfunction

    function automatic logic [31:0] q16(input int whole);
        return 32'(whole <<< FRAC_BITS);
    endfunction

    task automatic send_request(input logic [223:0] req, input bit has_fixed,
                                input logic [95:0] fixed);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= req;
        // The expectation is queued at the accepting edge so it is never late.
        do @(posedge aclk); while (!s_tready);
        if (has_fixed && fixed != rotate_vector(req)) begin
            $display("note: directed row disagrees with predictor, using fixed value");
        end
        rotated_q.push_back(has_fixed ? fixed : rotate_vector(req));
    endtask

    // Result side: random stalls, compare at each accepting edge.
    initial begin
        logic [95:0] want;
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (rotated_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = rotated_q.pop_front();
                for (int j = 0; j < 3; j++) begin
                    if (m_tdata[32*j +: 32] !== want[32*j +: 32]) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("field r_%s: expected %h, got %h",
                                     j == 0 ? "x" : (j == 1 ? "y" : "z"),
                                     want[32*j +: 32], m_tdata[32*j +: 32]);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no handshake on either side end the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX) begin
                timed_out = 1'b1;
                $display("rodrigues_axis_angle_rotate regression: fail");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        logic [223:0] req;
        logic [31:0] unit, mone;
        int mode;
        int waited;

        build_cordic_tables();
        unit = q16(1);
        mone = q16(-1);

        // Zero vector: the result is zero whatever the angle.
        row = '{f: '{0, 0, 0, 0, 0, unit, q16(77)}, has_fixed: 1, fixed: '{0, 0, 0}};
        rows.push_back(row);
        // Zero vector, axis and angle: v passes through scaled by cos 0.
        row = '{f: '{0, 0, 0, 0, 0, 0, 0}, has_fixed: 1, fixed: '{0, 0, 0}};
        rows.push_back(row);
        // Axis along z with quadrant, negative and wrapped angles.
        foreach (ang_list[i]) begin
            row = '{f: '{unit, q16(2), q16(-3), 0, 0, unit, ang_list[i]}, has_fixed: 0,
                    fixed: '{0, 0, 0}};
            rows.push_back(row);
        end
        // Axis not of unit length.
        row = '{f: '{unit, unit, unit, q16(3), mone, q16(2), q16(45)}, has_fixed: 0,
                fixed: '{0, 0, 0}};
        rows.push_back(row);
        // Huge operands drive every saturation stage.
        row = '{f: '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                     32'h80000000, 32'h7fffffff}, has_fixed: 0, fixed: '{0, 0, 0}};
        rows.push_back(row);
        row = '{f: '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000, 32'h80000000}, has_fixed: 0, fixed: '{0, 0, 0}};
        rows.push_back(row);
        row = '{f: '{32'hffffffff, 32'h00000001, 32'hffffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 32'hffffffff}, has_fixed: 0, fixed: '{0, 0, 0}};
        rows.push_back(row);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            for (int j = 0; j < 7; j++) req[32*j +: 32] = rows[i].f[j];
            send_request(req, rows[i].has_fixed,
                         {rows[i].fixed[2], rows[i].fixed[1], rows[i].fixed[0]});
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Hold the input until the pipeline has drained once, mid-run.
            if (n == RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                while (rotated_q.size() != 0 && !timed_out) @(posedge aclk);
            end
            mode = $urandom_range(0, 9);
            for (int j = 0; j < 7; j++) req[32*j +: 32] = $urandom;
            if (mode < 6) begin
                // Realistic magnitudes: vector and axis components in [-4.0, 4.0].
                for (int j = 0; j < 6; j++) begin
                    req[32*j +: 32] = 32'($signed($urandom_range(0, 32'h0008_0000)) -
                                          32'sh0004_0000);
                end
            end else if (mode < 8) begin
                // Angles exactly on and around the folding boundaries.
                req[192 +: 32] = q16(90 * $urandom_range(0, 8) - 360) +
                                 32'($signed($urandom_range(0, 4)) - 2);
            end
            send_request(req, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (rotated_q.size() != 0 && !timed_out) @(posedge aclk);
        waited = 0;
        while (waited < LATENCY * 2 && !timed_out) begin
            @(posedge aclk);
            waited++;
        end

        if (timed_out) begin
            $display("rodrigues_axis_angle_rotate regression: fail");
        end else if (mismatches == 0 && rotated_q.size() == 0) begin
            $display("rodrigues_axis_angle_rotate regression: pass");
        end else begin
            $display("rodrigues_axis_angle_rotate regression: fail");
        end
        $finish;
    end

endmodule
